// ===== rtl/gfa_pkg.sv =====
package gfa_pkg;

    localparam int FDEG = 131;

    typedef logic [FDEG-1:0] t_elem;
    typedef logic [FDEG:0]   t_wide;

    localparam t_wide POLY = 132'h8_0000_0000_0000_0000_0000_0000_0000_2007;
    localparam t_elem RED  = 131'h2007;
    localparam t_elem ONE  = 131'h1;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_MUL = 2'd1;
    localparam logic [1:0] MODE_SQR = 2'd2;
    localparam logic [1:0] MODE_INV = 2'd3;

    localparam logic [7:0] MUL_LAST = 8'(FDEG - 1);

    typedef struct packed {
        logic load;
        logic mul_step;
        logic inv_step;
        logic inv_fin;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic inv_done;
    } t_sts;

endpackage

// ===== rtl/gfa_in_if.sv =====
interface gfa_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] a_low;
    logic [63:0] a_mid;
    logic [2:0]  a_top;
    logic [63:0] b_low;
    logic [63:0] b_mid;
    logic [2:0]  b_top;
    logic [1:0]  mode;

    modport source (output valid, a_low, a_mid, a_top, b_low, b_mid, b_top, mode,
                    input ready);
    modport sink (input valid, a_low, a_mid, a_top, b_low, b_mid, b_top, mode,
                  output ready);
endinterface

// ===== rtl/gfa_out_if.sv =====
interface gfa_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] c_low;
    logic [63:0] c_mid;
    logic [2:0]  c_top;

    modport source (output valid, c_low, c_mid, c_top, input ready);
    modport sink (input valid, c_low, c_mid, c_top, output ready);
endinterface

// ===== rtl/gfa_datapath.sv =====
module gfa_datapath (
    input  logic          i_clk,
    input  gfa_pkg::t_cmd i_cmd,
    input  gfa_pkg::t_elem i_a,
    input  gfa_pkg::t_elem i_b,
    input  logic [1:0]    i_mode,
    output gfa_pkg::t_sts o_sts,
    output gfa_pkg::t_elem o_c
);
    import gfa_pkg::*;

    t_elem r_a, r_b, r_acc, r_g1, r_g2, r_c;
    t_wide r_u, r_v;
    logic [7:0] r_du, r_dv;

    t_elem n_acc, n_g1, n_g2;
    t_wide n_u, n_v;
    logic [7:0] n_du, n_dv;
    logic a_zero, u_one, v_one;

    function automatic t_elem half(input t_elem g);
        t_wide w;
        w = g[0] ? ({1'b0, g} ^ POLY) : {1'b0, g};
        return w[FDEG:1];
    endfunction

    assign a_zero = (i_a == '0);
    assign u_one  = (r_u == t_wide'(1));
    assign v_one  = (r_v == t_wide'(1));
    assign o_sts.inv_done = u_one || v_one;
    assign o_c = r_c;

    always_comb begin
        n_acc = {r_acc[FDEG-2:0], 1'b0} ^ (r_acc[FDEG-1] ? RED : '0)
              ^ (r_b[FDEG-1] ? r_a : '0);
        n_u = r_u; n_v = r_v; n_g1 = r_g1; n_g2 = r_g2; n_du = r_du; n_dv = r_dv;
        if (!r_u[0]) begin
            n_u = r_u >> 1;
            n_g1 = half(r_g1);
            n_du = r_du - 8'd1;
        end else if (!r_v[0]) begin
            n_v = r_v >> 1;
            n_g2 = half(r_g2);
            n_dv = r_dv - 8'd1;
        end else if (r_du > r_dv) begin
            n_u = r_u ^ r_v;
            n_g1 = r_g1 ^ r_g2;
        end else begin
            n_v = r_v ^ r_u;
            n_g2 = r_g2 ^ r_g1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a   <= i_a;
            r_b   <= (i_mode == MODE_SQR) ? i_a : i_b;
            r_acc <= (i_mode == MODE_ADD) ? (i_a ^ i_b) : '0;
            r_u   <= a_zero ? t_wide'(1) : {1'b0, i_a};
            r_v   <= POLY;
            r_g1  <= ONE;
            r_g2  <= '0;
            r_du  <= 8'(FDEG - 1);
            r_dv  <= 8'(FDEG);
        end
        if (i_cmd.mul_step) begin
            r_acc <= n_acc;
            r_b   <= {r_b[FDEG-2:0], 1'b0};
        end
        if (i_cmd.inv_step) begin
            r_u <= n_u; r_v <= n_v; r_g1 <= n_g1; r_g2 <= n_g2;
            r_du <= n_du; r_dv <= n_dv;
        end
        if (i_cmd.inv_fin) begin
            r_acc <= u_one ? r_g1 : r_g2;
        end
        if (i_cmd.out_load) begin
            r_c <= r_acc;
        end
    end

    a_inv_odd: assert property (@(posedge i_clk)
        i_cmd.inv_step && r_u[0] && r_v[0] |-> r_u != r_v)
        else $error("remainders equal during inversion");
    a_deg_bound: assert property (@(posedge i_clk)
        i_cmd.inv_step |-> (r_du != 8'd0 || r_u[0]) && (r_dv != 8'd0 || r_v[0]))
        else $error("degree bound underflow");
    a_no_mix: assert property (@(posedge i_clk)
        !(i_cmd.mul_step && i_cmd.inv_step))
        else $error("multiply and inversion step together");
endmodule

// ===== rtl/gfa_ctrl.sv =====
module gfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_mode,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  gfa_pkg::t_sts i_sts,
    output gfa_pkg::t_cmd o_cmd
);
    import gfa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_INV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [7:0] r_cnt, n_cnt;
    logic r_ovalid, n_ovalid;
    logic accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        o_cmd = '0;
        o_cmd.load = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cnt = '0;
                    case (i_mode)
                        MODE_MUL: n_state = S_MUL;
                        MODE_SQR: n_state = S_MUL;
                        MODE_INV: n_state = S_INV;
                        default:  n_state = S_FIN;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt = r_cnt + 8'd1;
                if (r_cnt == MUL_LAST) n_state = S_FIN;
            end
            S_INV: begin
                if (i_sts.inv_done) begin
                    o_cmd.inv_fin = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.inv_step = 1'b1;
                end
            end
            S_FIN: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ovalid = o_cmd.out_load ? 1'b1 : (r_ovalid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !r_ovalid || i_out_ready)
        else $error("result overwritten before taken");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |-> r_cnt <= MUL_LAST)
        else $error("multiply count out of range");
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_ovalid)
        else $error("loaded result not presented");
endmodule

// ===== rtl/gf2_131_field_alu.sv =====
// channel  dir  signals                                   beat
// i_in     in   valid ready a_low a_mid a_top b_* mode    operands a, b and mode
// o_out    out  valid ready c_low c_mid c_top             result c
//
// add is xored at load and then passed to the output register, multiply and square
// take one bit of b per cycle through the shift-and-reduce accumulator, and invert
// takes one shift or xor of the binary euclidean remainders per cycle.
// synchronous active-low reset clears the controller and the output valid.
// a new beat is taken once the previous result sits in the output register,
// even while that result waits on o_out.ready.
module gf2_131_field_alu (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gfa_in_if.sink    i_in,
    gfa_out_if.source o_out
);
    import gfa_pkg::*;

    t_cmd  cmd;
    t_sts  sts;
    t_elem op_a, op_b, res;

    assign op_a = {i_in.a_top, i_in.a_mid, i_in.a_low};
    assign op_b = {i_in.b_top, i_in.b_mid, i_in.b_low};

    gfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_mode      (i_in.mode),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gfa_datapath u_dp (
        .i_clk  (i_clk),
        .i_cmd  (cmd),
        .i_a    (op_a),
        .i_b    (op_b),
        .i_mode (i_in.mode),
        .o_sts  (sts),
        .o_c    (res)
    );

    assign o_out.c_low = res[63:0];
    assign o_out.c_mid = res[127:64];
    assign o_out.c_top = res[130:128];
endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import gfa_pkg::*;

    localparam int W2 = 2 * FDEG + 2;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef logic [W2-1:0] t_dbl;

    typedef struct {
        t_elem      a;
        t_elem      b;
        logic [1:0] mode;
        int         gap;
        bit         drain;
    } t_op;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gfa_in_if  in_ch ();
    gfa_out_if out_ch ();

    gf2_131_field_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #1 i_clk = ~i_clk;

    t_op    op_queue[$];
    t_elem  result_queue[$];
    int     mismatches = 0;
    bit     stim_done = 0;
    longint cycle = 0;
    int     gap_left = 0;
    int     stall_left = 0;

    // ---------------- field arithmetic ----------------
    function automatic int degree(t_dbl p);
        for (int i = W2 - 1; i >= 0; i--)
            if (p[i]) return i;
        return -1;
    endfunction

    function automatic t_elem reduce(t_dbl p);
        t_dbl m;
        m = t_dbl'(POLY);
        for (int i = W2 - 1; i >= FDEG; i--)
            if (p[i]) p ^= m << (i - FDEG);
        return p[FDEG-1:0];
    endfunction

    function automatic t_elem field_mul(t_elem a, t_elem b);
        t_dbl acc;
        acc = '0;
        for (int i = 0; i < FDEG; i++)
            if (b[i]) acc ^= t_dbl'(a) << i;
        return reduce(acc);
    endfunction

    function automatic t_elem field_inv(t_elem a);
        t_dbl u, v, g1, g2, t;
        int j;
        u = t_dbl'(a);
        v = t_dbl'(POLY);
        g1 = t_dbl'(ONE);
        g2 = '0;
        while (degree(u) > 0) begin
            j = degree(u) - degree(v);
            if (j < 0) begin
                j = -j;
                t = u; u = v; v = t;
                t = g1; g1 = g2; g2 = t;
            end
            u ^= v << j;
            g1 ^= g2 << j;
        end
        return reduce(g1);
    endfunction

    function automatic t_elem field_result(t_op op);
        case (op.mode)
            MODE_ADD: return op.a ^ op.b;
            MODE_MUL: return field_mul(op.a, op.b);
            MODE_SQR: return field_mul(op.a, op.a);
            default:  return field_inv(op.a);
        endcase
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic t_elem rand_elem();
        t_elem e;
        int kind;
        kind = $urandom_range(0, 9);
        e = t_elem'({$urandom, $urandom, $urandom, $urandom, $urandom});
        case (kind)
            0: e = '0;
            1: e = ONE;
            2: e = '1;
            3: e = t_elem'(1) << $urandom_range(0, FDEG - 1);
            4: e = e & t_elem'({$urandom, $urandom, $urandom, $urandom, $urandom})
                     & t_elem'({$urandom, $urandom, $urandom, $urandom, $urandom});
            5: e = e | (t_elem'(7) << 128);
            default: ;
        endcase
        return e;
    endfunction

    task automatic add_op(t_elem a, t_elem b, logic [1:0] mode, int gap, bit drain);
        t_op op;
        op.a = a;
        op.b = b;
        op.mode = mode;
        op.gap = gap;
        op.drain = drain;
        op_queue.push_back(op);
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s at cycle %0d: got %h expected %h", field, cycle, got, want);
        mismatches++;
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        bit launch;
        t_op op;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            gap_left = 0;
        end else if (!(in_ch.valid && !in_ch.ready)) begin
            if (in_ch.valid && in_ch.ready) begin
                op = op_queue.pop_front();
                result_queue.push_back(field_result(op));
            end
            launch = 0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (op_queue.size() > 0) begin
                if (!op_queue[0].drain || result_queue.size() == 0)
                    launch = 1;
            end
            if (launch) begin
                op = op_queue[0];
                in_ch.a_low <= op.a[63:0];
                in_ch.a_mid <= op.a[127:64];
                in_ch.a_top <= op.a[130:128];
                in_ch.b_low <= op.b[63:0];
                in_ch.b_mid <= op.b[127:64];
                in_ch.b_top <= op.b[130:128];
                in_ch.mode <= op.mode;
                gap_left = op.gap;
            end
            in_ch.valid <= launch;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_elem want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (result_queue.size() == 0) begin
                    $display("unexpected result beat at cycle %0d", cycle);
                    mismatches++;
                end else begin
                    want = result_queue.pop_front();
                    if (out_ch.c_low !== want[63:0])
                        report_mismatch("c_low", out_ch.c_low, want[63:0]);
                    if (out_ch.c_mid !== want[127:64])
                        report_mismatch("c_mid", out_ch.c_mid, want[127:64]);
                    if (out_ch.c_top !== want[130:128])
                        report_mismatch("c_top", 64'(out_ch.c_top), 64'(want[130:128]));
                end
                stall_left = ((cycle / 20000) % 4 == 0) ? 0 : $urandom_range(0, 8);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle++;
        if (cycle > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_elem top_bit;
        in_ch.valid = 1'b0;
        in_ch.a_low = '0;
        in_ch.a_mid = '0;
        in_ch.a_top = '0;
        in_ch.b_low = '0;
        in_ch.b_mid = '0;
        in_ch.b_top = '0;
        in_ch.mode = MODE_ADD;
        out_ch.ready = 1'b0;
        top_bit = t_elem'(1) << (FDEG - 1);

        // directed part
        add_op('0, '0, MODE_ADD, 0, 0);
        add_op('1, '1, MODE_ADD, 0, 0);
        add_op('1, '0, MODE_ADD, 0, 0);
        add_op('0, '1, MODE_ADD, 0, 0);
        add_op('1, '1, MODE_MUL, 0, 0);
        add_op(top_bit, top_bit, MODE_MUL, 0, 0);
        add_op('1, ONE, MODE_MUL, 0, 0);
        add_op('0, '1, MODE_MUL, 0, 0);
        add_op('1, '1, MODE_SQR, 0, 0);
        add_op(top_bit, '0, MODE_SQR, 0, 0);
        add_op(ONE, '1, MODE_SQR, 0, 0);
        add_op('0, '1, MODE_INV, 0, 0);
        add_op(ONE, '0, MODE_INV, 0, 0);
        add_op('1, '1, MODE_INV, 0, 0);
        add_op(top_bit, '0, MODE_INV, 0, 0);
        add_op(RED, '0, MODE_INV, 0, 0);
        add_op(t_elem'(2), '0, MODE_INV, 0, 0);

        // random part, with calm stretches and a full drain now and then
        for (int n = 0; n < 1450; n++) begin
            add_op(rand_elem(), rand_elem(), 2'($urandom_range(0, 3)),
                   ((n / 150) % 3 == 0) ? 0 : $urandom_range(0, 8),
                   (n % 300 == 0));
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_queue.size() > 0 || result_queue.size() > 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (mismatches == 0 && result_queue.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
